### src/vgc_pkg.sv
// Shared types, widths and codes for the voxel grid carve block.
`timescale 1ns / 1ps

package vgc_pkg;

  localparam int unsigned AxisMaxDefault = 32;

  // Carve arithmetic, all in units of 1/512
  localparam int unsigned SW    = 25;   // doubled start point
  localparam int unsigned DW    = 26;   // segment vector
  localparam int unsigned VW    = 26;   // centre minus start
  localparam int unsigned PW    = 52;   // single products and |d|^2, |v|^2
  localparam int unsigned TW    = 54;   // dot product, signed
  localparam int unsigned HW    = 26;   // limb of a 52-bit operand
  localparam int unsigned WW    = 104;  // full wide products
  localparam int unsigned XW    = 105;  // r^2|d|^2 + t^2
  localparam int unsigned RW    = 24;   // doubled radius
  localparam int unsigned R2W   = 48;   // radius squared
  localparam int unsigned R2HW  = 24;   // limb of radius squared
  localparam int unsigned VsW   = 16;   // voxel size register
  localparam int unsigned PipeDepth = 6;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CARVE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_GRID_DEPTH  = 2'd2,
    REG_VOXEL_SIZE  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_SETUP4,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [7:0]         pos_z;
    logic               write_value;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] start_z;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [23:0] end_z;
    logic [22:0]        radius;
  } in_t;

  typedef struct packed {
    logic voxel_value;
    logic accepted;
  } out_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic access;
    logic setup1;
    logic setup2;
    logic setup3;
    logic setup4;
    logic sweep_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic in_grid;
    logic seg_nonzero;
    logic grid_empty;
    logic sweep_last;
    logic clr_last;
  } dp_status_t;

endpackage

### src/vgc_ctrl.sv
// Sequencer for clearing, voxel access and the carve sweep.
`timescale 1ns / 1ps

module vgc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vgc_pkg::dp_status_t status_i,
  output vgc_pkg::ctrl_cmd_t  cmd_o
);
  import vgc_pkg::*;

  localparam int unsigned DrW = $clog2(PipeDepth);

  state_e         state_q, state_d;
  logic [DrW-1:0] drain_q, drain_d;
  logic           out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    drain_d    = drain_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        if (status_i.cmd == CMD_CARVE && status_i.seg_nonzero) state_d = ST_SETUP1;
        else state_d = ST_DONE;
      end
      ST_SETUP1: begin
        cmd_o.setup1 = 1'b1;
        state_d      = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd_o.setup2 = 1'b1;
        state_d      = ST_SETUP3;
      end
      ST_SETUP3: begin
        cmd_o.setup3 = 1'b1;
        state_d      = ST_SETUP4;
      end
      ST_SETUP4: begin
        cmd_o.setup4 = 1'b1;
        state_d      = status_i.grid_empty ? ST_DONE : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last voxels leave the test pipeline before answering
        drain_d = drain_q + DrW'(1);
        if (drain_q == DrW'(PipeDepth - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/vgc_dp.sv
// Occupancy memory, item registers and the pipelined capsule test.
`timescale 1ns / 1ps

module vgc_dp #(
  parameter int unsigned AXIS_MAX = vgc_pkg::AxisMaxDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(AXIS_MAX+1)-1:0]          n_x_i,
  input  logic [$clog2(AXIS_MAX+1)-1:0]          n_y_i,
  input  logic [$clog2(AXIS_MAX+1)-1:0]          n_z_i,
  input  logic [vgc_pkg::VsW-1:0]                voxel_size_i,
  input  vgc_pkg::in_t                           in_data_i,
  input  vgc_pkg::ctrl_cmd_t                     cmd_i,
  output vgc_pkg::dp_status_t                    status_o,
  output vgc_pkg::out_t                          out_data_o
);
  import vgc_pkg::*;

  localparam int unsigned NW    = $clog2(AXIS_MAX + 1);
  localparam int unsigned IdxW  = $clog2(AXIS_MAX);
  localparam int unsigned Depth = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CiW   = NW + 2;
  localparam int unsigned CW    = CiW + VsW + 1;

  // ---------------- item registers ----------------
  in_t                   item_q;
  logic signed [SW-1:0]  s_q [3];
  logic signed [DW-1:0]  d_q [3];
  logic [RW-1:0]         r_q;
  logic                  nonzero_q;

  logic signed [SW-1:0]  s_d [3];
  logic signed [DW-1:0]  d_d [3];
  logic signed [23:0]    st_in [3];
  logic signed [23:0]    en_in [3];

  assign st_in[0] = in_data_i.start_x;
  assign st_in[1] = in_data_i.start_y;
  assign st_in[2] = in_data_i.start_z;
  assign en_in[0] = in_data_i.end_x;
  assign en_in[1] = in_data_i.end_y;
  assign en_in[2] = in_data_i.end_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_d[k] = $signed({st_in[k], 1'b0});
      d_d[k] = DW'($signed({en_in[k], 1'b0})) - DW'(s_d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= in_data_i;
      s_q       <= s_d;
      d_q       <= d_d;
      r_q       <= {in_data_i.radius, 1'b0};
      nonzero_q <= (|d_d[0]) | (|d_d[1]) | (|d_d[2]);
    end
  end

  // ---------------- voxel access ----------------
  logic          in_grid;
  logic [AW-1:0] acc_addr;

  assign in_grid = ({1'b0, item_q.pos_x} < 9'(n_x_i)) &&
                   ({1'b0, item_q.pos_y} < 9'(n_y_i)) &&
                   ({1'b0, item_q.pos_z} < 9'(n_z_i));
  assign acc_addr = AW'((AW'(item_q.pos_z[IdxW-1:0]) * AW'(AXIS_MAX)
                        + AW'(item_q.pos_y[IdxW-1:0])) * AW'(AXIS_MAX)
                        + AW'(item_q.pos_x[IdxW-1:0]));

  // ---------------- carve setup ----------------
  logic signed [PW-1:0] dsq_q [3];
  logic [R2W-1:0]       r2_q;
  logic [PW-1:0]        dd_q;
  logic [R2HW+HW-1:0]   rp_q [4];
  logic [WW-1:0]        rr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup1) begin
      for (int k = 0; k < 3; k++) dsq_q[k] <= d_q[k] * d_q[k];
      r2_q <= r_q * r_q;
    end
    if (cmd_i.setup2) begin
      dd_q <= dsq_q[0][PW-1:0] + dsq_q[1][PW-1:0] + dsq_q[2][PW-1:0];
    end
    if (cmd_i.setup3) begin
      rp_q[0] <= r2_q[R2W-1:R2HW] * dd_q[PW-1:HW];
      rp_q[1] <= r2_q[R2W-1:R2HW] * dd_q[HW-1:0];
      rp_q[2] <= r2_q[R2HW-1:0]   * dd_q[PW-1:HW];
      rp_q[3] <= r2_q[R2HW-1:0]   * dd_q[HW-1:0];
    end
    if (cmd_i.setup4) begin
      rr_q <= (WW'(rp_q[0]) << (R2HW + HW)) + (WW'(rp_q[1]) << R2HW)
            + (WW'(rp_q[2]) << HW) + WW'(rp_q[3]);
    end
  end

  // ---------------- sweep counters ----------------
  logic [IdxW-1:0] idx_q [3];
  logic [NW-1:0]   n_ax  [3];
  logic [2:0]      at_end;
  logic [AW-1:0]   sweep_addr;

  assign n_ax[0] = n_x_i;
  assign n_ax[1] = n_y_i;
  assign n_ax[2] = n_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) at_end[k] = (NW'(idx_q[k]) == n_ax[k] - NW'(1));
  end

  assign sweep_addr = AW'((AW'(idx_q[2]) * AW'(AXIS_MAX) + AW'(idx_q[1])) * AW'(AXIS_MAX)
                          + AW'(idx_q[0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup4) begin
      for (int k = 0; k < 3; k++) idx_q[k] <= '0;
    end else if (cmd_i.sweep_step) begin
      // x runs fastest, then y, then z
      if (at_end[0]) begin
        idx_q[0] <= '0;
        if (at_end[1]) begin
          idx_q[1] <= '0;
          idx_q[2] <= idx_q[2] + IdxW'(1);
        end else begin
          idx_q[1] <= idx_q[1] + IdxW'(1);
        end
      end else begin
        idx_q[0] <= idx_q[0] + IdxW'(1);
      end
    end
  end

  // ---------------- test pipeline ----------------
  logic                  vld_q  [PipeDepth];
  logic [AW-1:0]         addr_q [PipeDepth];

  logic signed [CiW-1:0] ci [3];
  logic signed [CW-1:0]  cc [3];
  logic signed [VW-1:0]  v1_q [3];
  logic signed [PW-1:0]  vd2_q [3];
  logic signed [PW-1:0]  vsq2_q [3];
  logic signed [TW-1:0]  tsum;
  logic [PW-1:0]         t3_q, vv3_q;
  logic                  ok3_q, ok4_q, ok5_q, ok6_q;
  logic [PW-1:0]         pp4_q [4];
  logic [PW-1:0]         qq4_q [3];
  logic [WW-1:0]         p5_q, q5_q, p6_q;
  logic [XW-1:0]         s6_q;
  logic                  hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ci[k] = CiW'({idx_q[k], 1'b0}) - CiW'(n_ax[k]);
      cc[k] = ci[k] * $signed({1'b0, voxel_size_i});
    end
    tsum = TW'(vd2_q[0]) + TW'(vd2_q[1]) + TW'(vd2_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeDepth; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= cmd_i.sweep_step;
      for (int i = 1; i < PipeDepth; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q[0] <= sweep_addr;
    for (int i = 1; i < PipeDepth; i++) addr_q[i] <= addr_q[i-1];
    // stage 1: centre relative to start
    for (int k = 0; k < 3; k++) v1_q[k] <= VW'(cc[k]) - VW'(s_q[k]);
    // stage 2: per-axis products
    for (int k = 0; k < 3; k++) begin
      vd2_q[k]  <= v1_q[k] * d_q[k];
      vsq2_q[k] <= v1_q[k] * v1_q[k];
    end
    // stage 3: t and |v|^2, projection range check
    t3_q  <= tsum[PW-1:0];
    vv3_q <= vsq2_q[0][PW-1:0] + vsq2_q[1][PW-1:0] + vsq2_q[2][PW-1:0];
    ok3_q <= !tsum[TW-1] && (tsum <= $signed(TW'(dd_q)));
    // stage 4: partial products of |v|^2|d|^2 and t^2
    pp4_q[0] <= vv3_q[PW-1:HW] * dd_q[PW-1:HW];
    pp4_q[1] <= vv3_q[PW-1:HW] * dd_q[HW-1:0];
    pp4_q[2] <= vv3_q[HW-1:0]  * dd_q[PW-1:HW];
    pp4_q[3] <= vv3_q[HW-1:0]  * dd_q[HW-1:0];
    qq4_q[0] <= t3_q[PW-1:HW] * t3_q[PW-1:HW];
    qq4_q[1] <= t3_q[PW-1:HW] * t3_q[HW-1:0];
    qq4_q[2] <= t3_q[HW-1:0]  * t3_q[HW-1:0];
    ok4_q    <= ok3_q;
    // stage 5: assemble
    p5_q  <= (WW'(pp4_q[0]) << (2 * HW)) + ((WW'(pp4_q[1]) + WW'(pp4_q[2])) << HW)
           + WW'(pp4_q[3]);
    q5_q  <= (WW'(qq4_q[0]) << (2 * HW)) + (WW'(qq4_q[1]) << (HW + 1)) + WW'(qq4_q[2]);
    ok5_q <= ok4_q;
    // stage 6: distance test becomes |v|^2|d|^2 <= r^2|d|^2 + t^2
    p6_q  <= p5_q;
    s6_q  <= XW'(rr_q) + XW'(q5_q);
    ok6_q <= ok5_q;
  end

  assign hit = vld_q[PipeDepth-1] && ok6_q && (XW'(p6_q) <= s6_q);

  // ---------------- occupancy memory ----------------
  logic          mem_q [Depth];
  logic [AW-1:0] clr_q;
  logic          rd_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
  end

  always_comb begin
    we    = 1'b0;
    waddr = acc_addr;
    wdata = 1'b0;
    if (cmd_i.clr_en) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (hit) begin
      we    = 1'b1;
      waddr = addr_q[PipeDepth-1];
    end else if (cmd_i.access && item_q.command == CMD_WRITE && in_grid) begin
      we    = 1'b1;
      wdata = item_q.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[acc_addr];
  end

  // ---------------- result ----------------
  out_t out_q, out_d;

  always_comb begin
    out_d             = '0;
    out_d.voxel_value = (item_q.command == CMD_READ) && in_grid && rd_q;
    out_d.accepted    = ((item_q.command == CMD_READ || item_q.command == CMD_WRITE) && in_grid)
                      || (item_q.command == CMD_CARVE && nonzero_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_data_o = out_q;

  assign status_o.cmd         = cmd_e'(item_q.command);
  assign status_o.in_grid     = in_grid;
  assign status_o.seg_nonzero = nonzero_q;
  assign status_o.grid_empty  = (n_x_i == '0) || (n_y_i == '0) || (n_z_i == '0);
  assign status_o.sweep_last  = &at_end;
  assign status_o.clr_last    = (clr_q == AW'(Depth - 1));

endmodule

### src/voxel_grid_cylinder_carve.sv
// Top level: register port, size clamping, sequencer and datapath.
`timescale 1ns / 1ps

// Voxel occupancy map of AXIS_MAX^3 bits with read, write and capsule carve.
// After reset the map is swept clear, one voxel per cycle over all AXIS_MAX^3
// voxels (32768 by default), and no beat is taken until that is done; register
// writes work throughout. One item is handled at a time. A read, a write or a
// no-op goes through the access and done states before its result is loaded. A
// carve with a nonzero segment runs the setup states, sweeps width*height*depth
// voxels one per cycle through the single write port of the occupancy memory,
// then drains the 6-stage test pipeline. Sizes are clamped to AXIS_MAX.
module voxel_grid_cylinder_carve #(
  parameter int unsigned AXIS_MAX = vgc_pkg::AxisMaxDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vgc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vgc_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import vgc_pkg::*;

  localparam int unsigned NW = $clog2(AXIS_MAX + 1);

  logic [5:0]     grid_width_q, grid_height_q, grid_depth_q;
  logic [VsW-1:0] voxel_size_q;
  logic           wr_en;
  reg_e           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 6'd32;
      grid_height_q <= 6'd32;
      grid_depth_q  <= 6'd32;
      voxel_size_q  <= 16'd256;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[5:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[5:0];
        REG_GRID_DEPTH:  grid_depth_q  <= pwdata[5:0];
        REG_VOXEL_SIZE:  voxel_size_q  <= pwdata[VsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
      REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
      REG_GRID_DEPTH:  prdata = 32'(grid_depth_q);
      REG_VOXEL_SIZE:  prdata = 32'(voxel_size_q);
      default:         prdata = '0;
    endcase
  end

  // axis lengths in use, clamped to the map size
  logic [NW-1:0] n_x, n_y, n_z;

  assign n_x = (7'(grid_width_q)  > 7'(AXIS_MAX)) ? NW'(AXIS_MAX) : NW'(grid_width_q);
  assign n_y = (7'(grid_height_q) > 7'(AXIS_MAX)) ? NW'(AXIS_MAX) : NW'(grid_height_q);
  assign n_z = (7'(grid_depth_q)  > 7'(AXIS_MAX)) ? NW'(AXIS_MAX) : NW'(grid_depth_q);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  vgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  vgc_dp #(
    .AXIS_MAX (AXIS_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_x_i        (n_x),
    .n_y_i        (n_y),
    .n_z_i        (n_z),
    .voxel_size_i (voxel_size_q),
    .in_data_i    (in_data_i),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .out_data_o   (out_data_o)
  );

  // no beat is taken while the map is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.clr_en |-> !in_ready_o)
    else $error("input taken during clearing sweep");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while busy");

  // the sweep never overlaps a single-voxel access or the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.sweep_step |-> !ctrl_cmd.access && !ctrl_cmd.clr_en && !in_ready_o)
    else $error("sweep overlaps another memory user");

endmodule

### dv/voxel_grid_cylinder_carve_tb.sv
// Testbench for the voxel grid carve block: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module voxel_grid_cylinder_carve_tb;
  import vgc_pkg::*;

  localparam int unsigned AxisN = 32;
  localparam int unsigned InW   = $bits(in_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  voxel_grid_cylinder_carve dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow of the block's registers and occupancy map
  logic [5:0]  size_w = 6'd32, size_h = 6'd32, size_d = 6'd32;
  logic [15:0] vox_size = 16'd256;
  logic        occ_map [AxisN*AxisN*AxisN];

  out_t pending_beats [$];
  int   snd_idle = 0, rcv_idle = 0;
  bit   failed = 0;

  function automatic int clamp_axis(logic [5:0] r);
    return (r > AxisN) ? AxisN : int'(r);
  endfunction

  function automatic out_t predict_beat(in_t it);
    out_t o;
    int n [3];
    int idx [3];
    logic signed [23:0] st [3], en [3];
    logic signed [127:0] s [3], d [3], v [3];
    logic signed [127:0] dd, rr, rad, t, vv;
    bit nz;
    int a;
    o = '0;
    n[0] = clamp_axis(size_w); n[1] = clamp_axis(size_h); n[2] = clamp_axis(size_d);
    case (cmd_e'(it.command))
      CMD_READ, CMD_WRITE: begin
        if (it.pos_x < n[0] && it.pos_y < n[1] && it.pos_z < n[2]) begin
          a = (int'(it.pos_z) * AxisN + int'(it.pos_y)) * AxisN + int'(it.pos_x);
          if (cmd_e'(it.command) == CMD_READ) o.voxel_value = occ_map[a];
          else occ_map[a] = it.write_value;
          o.accepted = 1'b1;
        end
      end
      CMD_CARVE: begin
        st[0] = it.start_x; st[1] = it.start_y; st[2] = it.start_z;
        en[0] = it.end_x;   en[1] = it.end_y;   en[2] = it.end_z;
        nz = 0;
        dd = 0;
        for (int k = 0; k < 3; k++) begin
          s[k] = st[k];
          s[k] = 2 * s[k];
          d[k] = en[k];
          d[k] = 2 * d[k] - s[k];
          if (d[k] != 0) nz = 1;
          dd += d[k] * d[k];
        end
        if (nz) begin
          rad = 2 * it.radius;
          rr = rad * rad * dd;
          for (int z = 0; z < n[2]; z++)
            for (int y = 0; y < n[1]; y++)
              for (int x = 0; x < n[0]; x++) begin
                idx[0] = x; idx[1] = y; idx[2] = z;
                t = 0;
                vv = 0;
                for (int k = 0; k < 3; k++) begin
                  v[k] = (2 * idx[k] - n[k]) * longint'(vox_size);
                  v[k] = v[k] - s[k];
                  t += v[k] * d[k];
                  vv += v[k] * v[k];
                end
                if (t >= 0 && t <= dd && vv * dd - t * t <= rr)
                  occ_map[(z * AxisN + y) * AxisN + x] = 1'b0;
              end
          o.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_beat(in_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_beats.push_back(predict_beat(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    wait (pending_beats.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [15:0] val);
    drain();
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 4'(4 * int'(r)); pwdata = 32'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (r)
      REG_GRID_WIDTH:  size_w = val[5:0];
      REG_GRID_HEIGHT: size_h = val[5:0];
      REG_GRID_DEPTH:  size_d = val[5:0];
      REG_VOXEL_SIZE:  vox_size = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [5:0] w, logic [5:0] h, logic [5:0] d, logic [15:0] vs);
    write_reg(REG_GRID_WIDTH, 16'(w));
    write_reg(REG_GRID_HEIGHT, 16'(h));
    write_reg(REG_GRID_DEPTH, 16'(d));
    write_reg(REG_VOXEL_SIZE, vs);
  endtask

  function automatic in_t access_beat(cmd_e c, int x, int y, int z, bit val);
    in_t it;
    it = '0;
    it.command = c;
    it.pos_x = 8'(x); it.pos_y = 8'(y); it.pos_z = 8'(z);
    it.write_value = val;
    return it;
  endfunction

  function automatic in_t carve_beat(int sx, int sy, int sz, int ex, int ey, int ez, int r);
    in_t it;
    it = '0;
    it.command = CMD_CARVE;
    it.start_x = 24'(sx); it.start_y = 24'(sy); it.start_z = 24'(sz);
    it.end_x = 24'(ex);   it.end_y = 24'(ey);   it.end_z = 24'(ez);
    it.radius = 23'(r);
    return it;
  endfunction

  // Reset-size grid: access extremes, off-grid indices, no-op, a zero-length carve and a full-grid carve
  task automatic test_access_and_carve();
    send_beat(access_beat(CMD_WRITE, 0, 0, 0, 1));
    send_beat(access_beat(CMD_WRITE, 31, 31, 31, 1));
    send_beat(access_beat(CMD_WRITE, 16, 16, 17, 1));
    send_beat(access_beat(CMD_READ, 0, 0, 0, 0));
    send_beat(access_beat(CMD_READ, 31, 31, 31, 0));
    send_beat(access_beat(CMD_WRITE, 32, 0, 0, 1));
    send_beat(access_beat(CMD_READ, 255, 255, 255, 0));
    send_beat(access_beat(CMD_READ, 0, 32, 0, 0));
    send_beat(access_beat(CMD_NOP, 1, 1, 1, 1));
    send_beat(carve_beat(100, -5, 7, 100, -5, 7, 8388607));
    send_beat(carve_beat(0, 0, 0, 0, 0, 1024, 300));
    send_beat(access_beat(CMD_READ, 16, 16, 17, 0));
    send_beat(access_beat(CMD_READ, 0, 0, 0, 0));
  endtask

  // Size extremes: empty, clamped to a single row, zero and maximum voxel size
  task automatic test_size_extremes();
    set_grid(6'd0, 6'd4, 6'd4, 16'd256);
    send_beat(access_beat(CMD_WRITE, 0, 0, 0, 1));
    send_beat(carve_beat(-8388608, 0, 0, 8388607, 0, 0, 8388607));
    set_grid(6'd63, 6'd1, 6'd1, 16'd0);
    send_beat(access_beat(CMD_WRITE, 40, 0, 0, 1));
    send_beat(access_beat(CMD_WRITE, 31, 0, 0, 1));
    send_beat(carve_beat(0, 0, 0, 0, 0, 1, 0));
    send_beat(access_beat(CMD_READ, 31, 0, 0, 0));
    set_grid(6'd3, 6'd2, 6'd1, 16'd65535);
    send_beat(access_beat(CMD_WRITE, 2, 1, 0, 1));
    send_beat(carve_beat(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0));
    send_beat(access_beat(CMD_READ, 2, 1, 0, 0));
  endtask

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic in_t random_beat();
    in_t it;
    int nx, ny, nz, span;
    it = in_t'(InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom}));
    nx = clamp_axis(size_w); ny = clamp_axis(size_h); nz = clamp_axis(size_d);
    span = (nx + ny + nz) * int'(vox_size) + 16;
    case ($urandom_range(9))
      0, 1, 2: begin
        it.command = CMD_WRITE;
        it.write_value = ($urandom_range(3) != 0);
      end
      3, 4: it.command = CMD_READ;
      5, 6, 7: it.command = CMD_CARVE;
      default: ;   // fully random beat, no-ops included
    endcase
    if ($urandom_range(4) != 0) begin
      it.pos_x = 8'($urandom_range(nx)); it.pos_y = 8'($urandom_range(ny));
      it.pos_z = 8'($urandom_range(nz));
    end
    if (it.command == CMD_CARVE && $urandom_range(4) != 0) begin
      it.start_x = 24'(rand_span(span)); it.start_y = 24'(rand_span(span));
      it.start_z = 24'(rand_span(span));
      it.end_x = 24'(rand_span(span));   it.end_y = 24'(rand_span(span));
      it.end_z = 24'(rand_span(span));
      it.radius = 23'($urandom_range(span));
    end
    return it;
  endfunction

  task automatic test_random_phase(int s_idle, int r_idle, int count);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    set_grid(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)),
             16'($urandom_range(1, 600)));
    for (int i = 0; i < count; i++) begin
      send_beat(random_beat());
      if (i == count / 2) drain();   // sender holds off until all results are in
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %b", out_data_o);
        failed = 1;
      end else begin
        out_t exp_beat;
        exp_beat = pending_beats.pop_front();
        if (out_data_o.voxel_value !== exp_beat.voxel_value) begin
          $error("voxel_value expected %b actual %b", exp_beat.voxel_value,
                 out_data_o.voxel_value);
          failed = 1;
        end
        if (out_data_o.accepted !== exp_beat.accepted) begin
          $error("accepted expected %b actual %b", exp_beat.accepted, out_data_o.accepted);
          failed = 1;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < AxisN * AxisN * AxisN; i++) occ_map[i] = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_access_and_carve();
    test_size_extremes();
    test_random_phase(36, 71, 26);
    test_random_phase(71, 36, 26);
    test_random_phase(0, 0, 26);
    drain();
    if (!failed) $display("** voxel_grid_cylinder_carve: PASSED **");
    else $display("** voxel_grid_cylinder_carve: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** voxel_grid_cylinder_carve: FAILED **");
    $finish;
  end

endmodule
